// File: sv/taq_pkg.sv
// Package: types and constants for the timed action queue.
package taq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CAP_W           = 5;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_CANCEL = 3'd1;
    localparam logic [2:0] CMD_TICK   = 3'd2;
    localparam logic [2:0] CMD_DONE   = 3'd3;
    localparam logic [2:0] CMD_DRAIN  = 3'd4;
    localparam logic [2:0] CMD_STOP   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;
    localparam logic [1:0] ST_STOPPED = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] delay_ms;
        logic [15:0] tag;
        logic [15:0] handle;
    } taq_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        dispatch_valid;
        logic [15:0] dispatch_handle;
        logic [4:0]  cancelled_count;
        logic [4:0]  pending_count;
        logic        busy_res;
        logic        draining;
    } taq_out_t;

    typedef struct packed {
        logic [31:0] etime;
        logic [15:0] tag;
        logic [15:0] handle;
        logic [31:0] order;
    } taq_entry_t;

endpackage

// File: sv/taq_mem.sv
// Entry memory: one write port, one registered read port.
module taq_mem
    import taq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  taq_entry_t       wdata,
    input  logic [AW-1:0]    raddr,
    output taq_entry_t       rdata
);
    taq_entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/timed_action_queue.sv
// Top level: timed action queue with scanning controller over the entry memory.
//
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/ready  | taq_in_t
// out     | output    | out_valid/ready | taq_out_t
// cfg     | input     | cfg_we          | cfg_data (capacity_limit)
//
// Add, done, drain, stop and unused codes go from IDLE through OUT back to IDLE.
// Cancel and tick scan all entries through the single memory read port,
// passing through SCAN, FIN, RD and OUT before returning to IDLE.
// Reset clears valid bits, time, counters and flags; entry memory is not cleared.
// A result stays in the output register until taken; the next request is
// accepted only once the output register is free.
module timed_action_queue
    import taq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  taq_in_t             in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output taq_out_t            out_data,
    input  logic                cfg_we,
    input  logic [CAP_W-1:0]    cfg_data
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]             state_reg, state_next;
    taq_in_t                req_reg;
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [31:0]            now_reg, ins_reg;
    logic                   run_reg, wait_reg, stop_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic [AW-1:0]          ptr_reg;
    logic [AW-1:0]          rd_idx_reg;
    logic                   found_reg;
    logic [AW-1:0]          best_reg;
    logic [31:0]            best_dt_reg, best_do_reg;
    logic [15:0]            best_h_reg;
    logic [4:0]             removed_reg;
    logic                   ov_reg;
    taq_out_t               out_reg;

    logic                   we;
    logic [AW-1:0]          waddr;
    taq_entry_t             wdata, rdata;
    logic [CW-1:0]          pend;
    logic [AW-1:0]          free_idx;
    logic                   free_any;

    function automatic logic req_cmd_scan(input logic [2:0] c);
        return c == CMD_CANCEL || c == CMD_TICK;
    endfunction

    taq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(ptr_reg), .rdata(rdata)
    );

    always_comb
    begin
        pend = '0;
        free_idx = '0;
        free_any = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            pend = pend + CW'(valid_reg[i]);
            if (!valid_reg[i])
            begin
                free_idx = AW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic [31:0] lim;
    assign lim = (32'(cap_reg) > QUEUE_DEPTH) ? 32'(QUEUE_DEPTH) : 32'(cap_reg);

    logic add_ok;
    assign add_ok = state_reg == S_IDLE && in_valid && in_ready
        && in_data.cmd == CMD_ADD && !stop_reg && !wait_reg
        && (32'(pend) < lim) && free_any;
    assign we    = add_ok;
    assign waddr = free_idx;
    assign wdata = '{etime: now_reg + 32'(in_data.delay_ms), tag: in_data.tag,
                     handle: in_data.handle, order: ins_reg};

    assign in_ready  = state_reg == S_IDLE && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    // result fields known at accept time
    taq_out_t acc_out;
    always_comb
    begin
        acc_out = '0;
        if (in_data.cmd == CMD_ADD)
        begin
            if (stop_reg)
                acc_out.status = ST_STOPPED;
            else if (wait_reg)
                acc_out.status = ST_DRAIN;
            else if (!add_ok)
                acc_out.status = ST_FULL;
        end
        if (in_data.cmd == CMD_STOP)
            acc_out.cancelled_count = 5'(pend);
    end

    // scan compare on the registered read
    logic [31:0] dt, dob;
    logic        better;
    assign dt  = rdata.etime - now_reg;
    assign dob = rdata.order - ins_reg;
    assign better = !found_reg || ($signed(dt) < $signed(best_dt_reg))
        || (dt == best_dt_reg && $signed(dob) < $signed(best_do_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid && in_ready)
                    begin
                        if (req_cmd_scan(in_data.cmd))
                            state_next = S_SCAN;
                        else
                            state_next = S_OUT;
                    end
            S_SCAN: if (ptr_reg == LAST) state_next = S_FIN;
            S_FIN:  state_next = S_RD;
            S_RD:   state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic [CW-1:0] pend_after;
    always_comb
    begin
        pend_after = pend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            now_reg <= '0;
            ins_reg <= '0;
            run_reg <= 1'b0;
            wait_reg <= 1'b0;
            stop_reg <= 1'b0;
            cap_reg <= CAP_W'(16);
            ptr_reg <= '0;
            found_reg <= 1'b0;
            ov_reg <= 1'b0;
            removed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cap_reg <= cfg_data;
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        req_reg <= in_data;
                        ptr_reg <= '0;
                        found_reg <= 1'b0;
                        removed_reg <= '0;
                        out_reg <= acc_out;
                        unique case (in_data.cmd)
                            CMD_ADD:
                            begin
                                if (add_ok)
                                begin
                                    valid_reg[free_idx] <= 1'b1;
                                    ins_reg <= ins_reg + 32'd1;
                                end
                            end
                            CMD_CANCEL: ;
                            CMD_TICK:
                                now_reg <= now_reg + 32'd1;
                            CMD_DONE:
                                run_reg <= 1'b0;
                            CMD_DRAIN:
                                if (!stop_reg && (pend != '0 || run_reg))
                                    wait_reg <= 1'b1;
                            CMD_STOP:
                            begin
                                valid_reg <= '0;
                                stop_reg <= 1'b1;
                                wait_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (ptr_reg != LAST)
                        ptr_reg <= ptr_reg + AW'(1);
                    rd_idx_reg <= ptr_reg;
                end
                default: ;
            endcase
            // evaluate the entry read in the previous cycle
            if (state_reg == S_SCAN && ptr_reg != '0 || state_reg == S_FIN)
            begin
                if (valid_reg[rd_idx_reg])
                begin
                    if (req_reg.cmd == CMD_CANCEL)
                    begin
                        if (req_reg.tag == '0 || rdata.tag == req_reg.tag)
                        begin
                            valid_reg[rd_idx_reg] <= 1'b0;
                            removed_reg <= removed_reg + 5'd1;
                        end
                    end
                    else if (better)
                    begin
                        found_reg <= 1'b1;
                        best_reg <= rd_idx_reg;
                        best_dt_reg <= dt;
                        best_do_reg <= dob;
                        best_h_reg <= rdata.handle;
                    end
                end
            end
            if (state_reg == S_RD)
            begin
                if (req_reg.cmd == CMD_CANCEL)
                    out_reg.cancelled_count <= removed_reg;
                else if (found_reg && !run_reg && !stop_reg
                         && $signed(best_dt_reg) <= 0)
                begin
                    valid_reg[best_reg] <= 1'b0;
                    run_reg <= 1'b1;
                    out_reg.dispatch_valid <= 1'b1;
                    out_reg.dispatch_handle <= best_h_reg;
                end
            end
            if (state_reg == S_OUT)
            begin
                out_reg.pending_count <= 5'(pend_after);
                out_reg.busy_res <= run_reg;
                out_reg.draining <= wait_reg && !(pend == '0 && !run_reg);
                if (pend == '0 && !run_reg)
                    wait_reg <= 1'b0;
                ov_reg <= 1'b1;
            end
        end
    end

    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("request taken while busy");
    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");
    a_stop_noadd: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> !we)
        else $error("write after stop");
endmodule
